// ===== rtl/pwc_pkg.sv =====
// Shared types, constants and helpers of the PID unit with integral clamp.
`default_nettype none
package pwc_pkg;

  localparam int MulSteps = 32;
  localparam int DivSteps = 80;

  localparam logic [31:0] MsPerSec = 32'd1000;

  localparam logic [1:0] STAT_FIRST   = 2'd0;
  localparam logic [1:0] STAT_SHORT   = 2'd1;
  localparam logic [1:0] STAT_COMPUTE = 2'd2;
  localparam logic [1:0] STAT_RESTART = 2'd3;

  localparam logic [2:0] REG_PROP   = 3'd0;
  localparam logic [2:0] REG_INT    = 3'd1;
  localparam logic [2:0] REG_DERIV  = 3'd2;
  localparam logic [2:0] REG_LOW    = 3'd3;
  localparam logic [2:0] REG_HIGH   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_MSTART,
    ST_IMUL,
    ST_ISTART,
    ST_IDIV,
    ST_DSTART,
    ST_DDIV,
    ST_FIN1,
    ST_FIN2,
    ST_DONE
  } pwc_state_t;

  typedef struct packed {
    logic start;
  } pwc_unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pwc_unit_st_t;

  // low limit tested first, then high; limits are integers, values Q.16
  function automatic logic signed [31:0] clamp_q16(input logic signed [61:0] x,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
    logic signed [61:0] lo_w;
    logic signed [61:0] hi_w;
    lo_w = {{30{lo[15]}}, lo, 16'h0000};
    hi_w = {{30{hi[15]}}, hi, 16'h0000};
    if (x < lo_w) begin
      clamp_q16 = {lo, 16'h0000};
    end else if (x > hi_w) begin
      clamp_q16 = {hi, 16'h0000};
    end else begin
      clamp_q16 = x[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pwc_serial_mul.sv =====
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module pwc_serial_mul (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pwc_pkg::pwc_unit_ctl_t ctl,
  input  wire logic [47:0]          a,
  input  wire logic [31:0]          b,
  output pwc_pkg::pwc_unit_st_t     st,
  output logic [79:0]               prod
);

  logic [79:0] acc_r;
  logic [47:0] a_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [48:0] sum_nxt;

  assign sum_nxt = {1'b0, acc_r[79:32]} + (acc_r[0] ? {1'b0, a_r} : 49'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(pwc_pkg::MulSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= a;
      acc_r <= {48'd0, b};
    end else if (busy_r) begin
      acc_r <= {sum_nxt, acc_r[31:1]};
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign prod    = acc_r;

endmodule
`default_nettype wire

// ===== rtl/pwc_serial_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pwc_serial_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pwc_pkg::pwc_unit_ctl_t ctl,
  input  wire logic [79:0]            dividend,
  input  wire logic [31:0]            divisor,
  output pwc_pkg::pwc_unit_st_t       st,
  output logic [79:0]                 quot
);

  logic [79:0] dvd_r;
  logic [79:0] quot_r;
  logic [31:0] dvs_r;
  logic [31:0] rem_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] trial_nxt;
  logic        ge_nxt;
  logic [32:0] diff_nxt;

  assign trial_nxt = {rem_r, dvd_r[79]};
  assign ge_nxt    = trial_nxt >= {1'b0, dvs_r};
  assign diff_nxt  = trial_nxt - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(pwc_pkg::DivSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[78:0], 1'b0};
      rem_r  <= ge_nxt ? diff_nxt[31:0] : trial_nxt[31:0];
      quot_r <= {quot_r[78:0], ge_nxt};
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign quot    = quot_r;

endmodule
`default_nettype wire

// ===== rtl/pid_with_windup_clamp_unit.sv =====
// Top level: PID controller with clamped integral, serial multiply and divide.
// Sequencing: restart, first step and short interval go from idle straight to
// the done state; a computed step runs a serial multiply and two serial
// divides, then two finishing states, before the result is registered.
// Throughput: one item at a time; input stalls while an item is in work.
// Reset: synchronous, active low; state cleared, limits -255/255, gains 0.
`default_nettype none
module pid_with_windup_clamp_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic signed [15:0] in_target,
  input  wire logic signed [15:0] in_measured,
  input  wire logic [31:0]        in_now_ms,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_drive,
  output logic [1:0]              out_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  pwc_pkg::pwc_state_t state_r, state_nxt;

  logic signed [31:0] prop_r, int_r, deriv_r;
  logic signed [15:0] lo_r, hi_r;
  logic signed [47:0] integ_r;
  logic signed [16:0] last_err_r;
  logic [31:0]        last_stamp_r;
  logic               started_r;

  logic signed [16:0] err_r;
  logic [31:0]        dt_r, now_r;
  logic signed [48:0] p_r;
  logic [47:0]        imag_r;
  logic               isign_r;
  logic [48:0]        dmag_r;
  logic               dsign_r;
  logic signed [41:0] incr_r;
  logic signed [60:0] d_r;
  logic signed [15:0] drive_r;
  logic [1:0]         status_r;
  logic               out_valid_r;
  logic signed [15:0] out_drive_r;
  logic [1:0]         out_status_r;

  pwc_pkg::pwc_unit_ctl_t mul_ctl, div_ctl;
  pwc_pkg::pwc_unit_st_t  mul_st, div_st;
  logic [79:0] mul_prod, div_quot, div_dvd;
  logic [31:0] div_dvs;

  logic               accept;
  logic signed [16:0] err_in;
  logic [31:0]        dt_in;
  logic signed [48:0] p_prod, i_prod;
  logic signed [17:0] de;
  logic signed [49:0] d_prod;
  logic [79:0]        dnum;
  logic [40:0]        incr_mag;
  logic signed [49:0] isum;
  logic signed [31:0] integ_cl, sum_cl;
  logic signed [61:0] sum_w;
  logic signed [60:0] dq;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = state_r != pwc_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;
  assign err_in    = 17'(in_target) - 17'(in_measured);
  assign dt_in     = in_now_ms - last_stamp_r;

  assign p_prod = 49'(prop_r) * 49'(err_r);
  assign i_prod = 49'(int_r) * 49'(err_r);
  assign de     = 18'(err_r) - 18'(last_err_r);
  assign d_prod = 50'(deriv_r) * 50'(de);

  assign dnum = ({31'd0, dmag_r} << 10) - ({31'd0, dmag_r} << 4) - ({31'd0, dmag_r} << 3);
  assign incr_mag = (div_quot > 80'h100_0000_0000) ? 41'h100_0000_0000 : div_quot[40:0];

  assign isum     = 50'(integ_r) + 50'(incr_r);
  assign integ_cl = pwc_pkg::clamp_q16(62'(isum), lo_r, hi_r);
  assign dq       = dsign_r ? -61'(div_quot[59:0]) : 61'(div_quot[59:0]);
  assign sum_w    = 62'(p_r) + 62'(integ_r) + 62'(d_r);
  assign sum_cl   = pwc_pkg::clamp_q16(sum_w, lo_r, hi_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pwc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation || !started_r || dt_in <= 32'd1) begin
            state_nxt = pwc_pkg::ST_DONE;
          end else begin
            state_nxt = pwc_pkg::ST_PROD;
          end
        end
      end
      pwc_pkg::ST_PROD:   state_nxt = pwc_pkg::ST_MSTART;
      pwc_pkg::ST_MSTART: state_nxt = pwc_pkg::ST_IMUL;
      pwc_pkg::ST_IMUL:   if (mul_st.done) state_nxt = pwc_pkg::ST_ISTART;
      pwc_pkg::ST_ISTART: state_nxt = pwc_pkg::ST_IDIV;
      pwc_pkg::ST_IDIV:   if (div_st.done) state_nxt = pwc_pkg::ST_DSTART;
      pwc_pkg::ST_DSTART: state_nxt = pwc_pkg::ST_DDIV;
      pwc_pkg::ST_DDIV:   if (div_st.done) state_nxt = pwc_pkg::ST_FIN1;
      pwc_pkg::ST_FIN1:   state_nxt = pwc_pkg::ST_FIN2;
      pwc_pkg::ST_FIN2:   state_nxt = pwc_pkg::ST_DONE;
      pwc_pkg::ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = pwc_pkg::ST_IDLE;
      default:            state_nxt = pwc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_ctl.start = 1'b0;
    div_ctl.start = 1'b0;
    div_dvd       = mul_prod;
    div_dvs       = pwc_pkg::MsPerSec;
    case (state_r)
      pwc_pkg::ST_MSTART: mul_ctl.start = 1'b1;
      pwc_pkg::ST_ISTART: div_ctl.start = 1'b1;
      pwc_pkg::ST_DSTART: begin
        div_ctl.start = 1'b1;
        div_dvd       = dnum;
        div_dvs       = dt_r;
      end
      default: begin
        mul_ctl.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pwc_pkg::ST_IDLE;
      prop_r       <= '0;
      int_r        <= '0;
      deriv_r      <= '0;
      lo_r         <= -16'sd255;
      hi_r         <= 16'sd255;
      integ_r      <= '0;
      last_err_r   <= '0;
      last_stamp_r <= '0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pwc_pkg::REG_PROP:  prop_r  <= cfg_data;
          pwc_pkg::REG_INT:   int_r   <= cfg_data;
          pwc_pkg::REG_DERIV: deriv_r <= cfg_data;
          pwc_pkg::REG_LOW:   lo_r    <= cfg_data[15:0];
          pwc_pkg::REG_HIGH:  hi_r    <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (in_operation) begin
          integ_r      <= '0;
          last_err_r   <= '0;
          last_stamp_r <= in_now_ms;
          started_r    <= 1'b0;
        end else if (!started_r) begin
          last_err_r   <= err_in;
          last_stamp_r <= in_now_ms;
          started_r    <= 1'b1;
        end
      end
      if (state_r == pwc_pkg::ST_FIN1) begin
        integ_r      <= 48'(integ_cl);
        last_err_r   <= err_r;
        last_stamp_r <= now_r;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == pwc_pkg::ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r   <= err_in;
      dt_r    <= dt_in;
      now_r   <= in_now_ms;
      drive_r <= '0;
      if (in_operation) begin
        status_r <= pwc_pkg::STAT_RESTART;
      end else if (!started_r) begin
        status_r <= pwc_pkg::STAT_FIRST;
      end else if (dt_in <= 32'd1) begin
        status_r <= pwc_pkg::STAT_SHORT;
      end else begin
        status_r <= pwc_pkg::STAT_COMPUTE;
      end
    end
    if (state_r == pwc_pkg::ST_PROD) begin
      p_r     <= p_prod;
      isign_r <= i_prod[48];
      imag_r  <= i_prod[48] ? 48'(-i_prod) : i_prod[47:0];
      dsign_r <= d_prod[49];
      dmag_r  <= d_prod[49] ? 49'(-d_prod) : d_prod[48:0];
    end
    if (state_r == pwc_pkg::ST_DSTART) begin
      incr_r <= isign_r ? -42'(incr_mag) : 42'(incr_mag);
    end
    if (state_r == pwc_pkg::ST_FIN1) begin
      d_r <= dq;
    end
    if (state_r == pwc_pkg::ST_FIN2) begin
      drive_r <= sum_cl[31:16] + {15'd0, sum_cl[31] && (sum_cl[15:0] != 16'd0)};
    end
    if (state_r == pwc_pkg::ST_DONE && (!out_valid_r || !out_stall)) begin
      out_drive_r  <= drive_r;
      out_status_r <= status_r;
    end
  end

  pwc_serial_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mul_ctl),
    .a    (imag_r),
    .b    (dt_r),
    .st   (mul_st),
    .prod (mul_prod)
  );

  pwc_serial_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .st      (div_st),
    .quot    (div_quot)
  );

  assign out_valid  = out_valid_r;
  assign out_drive  = out_drive_r;
  assign out_status = out_status_r;

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_st.done |-> state_r == pwc_pkg::ST_IMUL)
    else $error("multiplier done outside multiply state");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == pwc_pkg::ST_IDIV || state_r == pwc_pkg::ST_DDIV))
    else $error("divider done outside divide states");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != pwc_pkg::ST_IDLE)
    else $error("accepted word left no work");

endmodule
`default_nettype wire
